// File: rtl/core/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg: shared types and constants for the rectangle fill and blit engine
// Command and result payloads, the internal work descriptor, op and register
// codes, and default sizes.
// ----------------------------------------------------------------------------
package rfb_pkg;

    // default sizes
    localparam int PIXEL_WORDS_DEF = 65536;
    localparam int MAX_SIDE_DEF    = 1024;

    // widest pixel memory index the descriptor can carry
    localparam int MAX_ADDR_W  = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int COUNT_W     = 17;
    localparam int DIM_W       = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_FILL  = 2'd2,
        MODE_COPY  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DST_BASE   = 3'd0,
        CFG_DST_WIDTH  = 3'd1,
        CFG_DST_HEIGHT = 3'd2,
        CFG_SRC_BASE   = 3'd3,
        CFG_SRC_WIDTH  = 3'd4,
        CFG_SRC_HEIGHT = 3'd5,
        CFG_DEEP       = 3'd6
    } t_cfg_index;

    // what the back end does per pixel
    typedef enum logic [1:0] {
        OP_FILL = 2'd0,
        OP_COPY = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_WALK = 2'd1,
        BK_TAIL = 2'd2
    } t_back_state;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] address;
        logic [31:0] value;
        logic        has_rect;
        logic [9:0]  rect_x;
        logic [9:0]  rect_y;
        logic [10:0] rect_w;
        logic [10:0] rect_h;
        logic        has_dest;
        logic [9:0]  dest_x;
        logic [9:0]  dest_y;
    } t_cmd;

    typedef struct packed {
        logic [31:0]        read_data;
        logic [COUNT_W-1:0] pixels_written;
    } t_result;

    // one classified transaction, ready to walk
    typedef struct packed {
        t_op                   op;
        logic                  deep;
        logic [31:0]           value;
        logic [MAX_ADDR_W-1:0] src_addr;
        logic [MAX_ADDR_W-1:0] dst_addr;
        logic [DIM_W-1:0]      src_stride;
        logic [DIM_W-1:0]      dst_stride;
        logic [DIM_W-1:0]      ncols;
        logic [DIM_W-1:0]      nrows;
    } t_desc;

endpackage

// File: rtl/core/rfb_front.sv
// ----------------------------------------------------------------------------
// rfb_front: configuration registers and command classification
// Clips each rectangle against the surfaces and turns it into a start
// address, strides and a column/row count for the back end.
// ----------------------------------------------------------------------------
module rfb_front #(
    parameter int MAX_SIDE = rfb_pkg::MAX_SIDE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rfb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rfb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  rfb_pkg::t_cmd                    i_cmd,
    input  logic                             i_full,
    output logic                             o_push,
    output rfb_pkg::t_desc                   o_desc
);
    import rfb_pkg::*;

    localparam logic [12:0] MaxSide = 13'(MAX_SIDE);

    logic [15:0]      r_dst_base, r_src_base;
    logic [DIM_W-1:0] r_dst_width, r_dst_height, r_src_width, r_src_height;
    logic             r_deep;

    function automatic logic [DIM_W-1:0] side_f(input logic [DIM_W-1:0] v);
        side_f = ({2'b00, v} > MaxSide) ? MaxSide[DIM_W-1:0] : v;
    endfunction

    function automatic logic [11:0] min12(input logic [11:0] a, input logic [11:0] b);
        min12 = (a < b) ? a : b;
    endfunction

    function automatic logic [DIM_W-1:0] span(input logic [11:0] lo, input logic [11:0] hi);
        span = (hi > lo) ? DIM_W'(hi - lo) : '0;
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_base   <= '0;
            r_dst_width  <= '0;
            r_dst_height <= '0;
            r_src_base   <= '0;
            r_src_width  <= '0;
            r_src_height <= '0;
            r_deep       <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DST_BASE:   r_dst_base   <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[DIM_W-1:0];
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_BASE:   r_src_base   <= i_cfg_data;
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[DIM_W-1:0];
                CFG_DEEP:       r_deep       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] dw, dh, sw, sh;
    logic [11:0]      rx0, ry0, rx1_d, ry1_d, rx1_s, ry1_s, dx0, dy0;
    logic [DIM_W-1:0] fcols, frows, scols, srows, dcols, drows, ccols, crows;
    logic [9:0]       d_row, d_col;
    logic [20:0]      dprod, sprod;
    logic [31:0]      dsum, ssum;
    logic [31:0]      value_m;

    always_comb begin
        dw = side_f(r_dst_width);
        dh = side_f(r_dst_height);
        sw = side_f(r_src_width);
        sh = side_f(r_src_height);

        rx0 = i_cmd.has_rect ? 12'(i_cmd.rect_x) : '0;
        ry0 = i_cmd.has_rect ? 12'(i_cmd.rect_y) : '0;
        // rectangle ends clipped to the surface
        rx1_d = i_cmd.has_rect ? min12(12'(i_cmd.rect_x) + 12'(i_cmd.rect_w), 12'(dw))
                               : 12'(dw);
        ry1_d = i_cmd.has_rect ? min12(12'(i_cmd.rect_y) + 12'(i_cmd.rect_h), 12'(dh))
                               : 12'(dh);
        rx1_s = i_cmd.has_rect ? min12(12'(i_cmd.rect_x) + 12'(i_cmd.rect_w), 12'(sw))
                               : 12'(sw);
        ry1_s = i_cmd.has_rect ? min12(12'(i_cmd.rect_y) + 12'(i_cmd.rect_h), 12'(sh))
                               : 12'(sh);
        dx0 = i_cmd.has_dest ? 12'(i_cmd.dest_x) : '0;
        dy0 = i_cmd.has_dest ? 12'(i_cmd.dest_y) : '0;

        fcols = span(rx0, rx1_d);
        frows = span(ry0, ry1_d);
        scols = span(rx0, rx1_s);
        srows = span(ry0, ry1_s);
        dcols = span(dx0, 12'(dw));
        drows = span(dy0, 12'(dh));
        ccols = (scols < dcols) ? scols : dcols;
        crows = (srows < drows) ? srows : drows;

        d_row = (i_cmd.mode == MODE_COPY) ? dy0[9:0] : ry0[9:0];
        d_col = (i_cmd.mode == MODE_COPY) ? dx0[9:0] : rx0[9:0];
        dprod = 21'(d_row) * 21'(dw);
        sprod = 21'(ry0[9:0]) * 21'(sw);
        dsum  = 32'(r_dst_base) + 32'(dprod) + 32'(d_col);
        ssum  = 32'(r_src_base) + 32'(sprod) + 32'(rx0);

        value_m = r_deep ? i_cmd.value : {24'd0, i_cmd.value[7:0]};

        o_desc            = '0;
        o_desc.deep       = r_deep;
        o_desc.value      = value_m;
        o_desc.src_stride = sw;
        o_desc.dst_stride = dw;
        o_desc.src_addr   = ssum[MAX_ADDR_W-1:0];
        o_desc.dst_addr   = dsum[MAX_ADDR_W-1:0];
        case (i_cmd.mode)
            MODE_WRITE: begin
                o_desc.op       = OP_FILL;
                o_desc.dst_addr = MAX_ADDR_W'(i_cmd.address);
                o_desc.ncols    = DIM_W'(1);
                o_desc.nrows    = DIM_W'(1);
            end
            MODE_READ: begin
                o_desc.op       = OP_READ;
                o_desc.src_addr = MAX_ADDR_W'(i_cmd.address);
                o_desc.ncols    = DIM_W'(1);
                o_desc.nrows    = DIM_W'(1);
            end
            MODE_FILL: begin
                o_desc.op    = OP_FILL;
                o_desc.ncols = fcols;
                o_desc.nrows = frows;
            end
            default: begin
                o_desc.op    = OP_COPY;
                o_desc.ncols = ccols;
                o_desc.nrows = crows;
            end
        endcase
    end

    assign busy   = i_full;
    assign o_push = start && !i_full;

endmodule

// File: rtl/core/rfb_fifo.sv
// ----------------------------------------------------------------------------
// rfb_fifo: short descriptor queue between front and back end
// ----------------------------------------------------------------------------
module rfb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rfb_pkg::t_desc i_desc,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rfb_pkg::t_desc o_desc
);
    import rfb_pkg::*;

    localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FillW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0]  LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [FillW-1:0] Depth   = FillW'(QUEUE_DEPTH);

    t_desc            r_entry [QUEUE_DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FillW-1:0] r_fill;
    logic             do_push, do_pop;

    assign o_full  = (r_fill == Depth);
    assign o_valid = (r_fill != '0);
    assign o_desc  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// File: rtl/core/rfb_back.sv
// ----------------------------------------------------------------------------
// rfb_back: pixel walker and pixel memory
// Walks one pixel per cycle row by row. Copies read the source in the cycle
// before the destination write; a same-cycle bypass keeps overlap exact.
// ----------------------------------------------------------------------------
module rfb_back #(
    parameter int PIXEL_WORDS = rfb_pkg::PIXEL_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  rfb_pkg::t_desc   i_desc,
    output logic             o_pop,
    output logic             o_done,
    output rfb_pkg::t_result o_result
);
    import rfb_pkg::*;

    localparam int AW = $clog2(PIXEL_WORDS);

    t_back_state r_state, n_state;

    t_op              r_op, n_op;
    logic             r_deep, n_deep;
    logic [31:0]      r_value, n_value;
    logic [DIM_W-1:0] r_src_stride, n_src_stride, r_dst_stride, n_dst_stride;
    logic [DIM_W-1:0] r_ncols, n_ncols, r_col_left, n_col_left, r_row_left, n_row_left;
    logic [AW-1:0]    r_src_row, n_src_row, r_src_ptr, n_src_ptr;
    logic [AW-1:0]    r_dst_row, n_dst_row, r_dst_ptr, n_dst_ptr;
    logic [COUNT_W-1:0] r_count, n_count;
    logic             r_cp_valid, n_cp_valid;
    logic [AW-1:0]    r_cp_addr, n_cp_addr;
    logic             r_done, n_done;
    t_result          r_result, n_result;

    logic [31:0]   r_mem [PIXEL_WORDS];
    logic [31:0]   r_rdata, r_bypdata;
    logic          r_byp;
    logic [31:0]   rdata_eff, rdata_m;

    logic          desc_empty, last_col, last_pix;
    logic          issue, fill_wr, tail;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] src_next_row, dst_next_row;

    assign desc_empty = (i_desc.ncols == '0) || (i_desc.nrows == '0);
    assign last_col   = (r_col_left == DIM_W'(1));
    assign last_pix   = last_col && (r_row_left == DIM_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_valid) begin
                    n_state = desc_empty ? BK_TAIL : BK_WALK;
                end
            end
            BK_WALK: begin
                if (last_pix) begin
                    n_state = BK_TAIL;
                end
            end
            BK_TAIL: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop   = 1'b0;
        issue   = 1'b0;
        tail    = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = i_valid;
            BK_WALK: issue = 1'b1;
            BK_TAIL: tail  = 1'b1;
            default: ;
        endcase
    end

    assign fill_wr   = issue && (r_op == OP_FILL);
    assign rdata_eff = r_byp ? r_bypdata : r_rdata;
    assign rdata_m   = r_deep ? rdata_eff : {24'd0, rdata_eff[7:0]};

    // single write port: pending copy write or fill write, never both
    assign we    = r_cp_valid || fill_wr;
    assign waddr = r_cp_valid ? r_cp_addr : r_dst_ptr;
    assign wdata = r_cp_valid ? rdata_m : r_value;

    assign src_next_row = r_src_row + AW'(r_src_stride);
    assign dst_next_row = r_dst_row + AW'(r_dst_stride);

    always_comb begin
        n_op         = r_op;
        n_deep       = r_deep;
        n_value      = r_value;
        n_src_stride = r_src_stride;
        n_dst_stride = r_dst_stride;
        n_ncols      = r_ncols;
        n_col_left   = r_col_left;
        n_row_left   = r_row_left;
        n_src_row    = r_src_row;
        n_src_ptr    = r_src_ptr;
        n_dst_row    = r_dst_row;
        n_dst_ptr    = r_dst_ptr;
        n_count      = r_count;
        n_cp_valid   = 1'b0;
        n_cp_addr    = r_dst_ptr;
        n_done       = tail;
        n_result     = r_result;

        if (o_pop) begin
            n_op         = i_desc.op;
            n_deep       = i_desc.deep;
            n_value      = i_desc.value;
            n_src_stride = i_desc.src_stride;
            n_dst_stride = i_desc.dst_stride;
            n_ncols      = i_desc.ncols;
            n_col_left   = i_desc.ncols;
            n_row_left   = i_desc.nrows;
            n_src_row    = i_desc.src_addr[AW-1:0];
            n_src_ptr    = i_desc.src_addr[AW-1:0];
            n_dst_row    = i_desc.dst_addr[AW-1:0];
            n_dst_ptr    = i_desc.dst_addr[AW-1:0];
            n_count      = '0;
        end

        if (issue) begin
            n_cp_valid = (r_op == OP_COPY);
            if (r_op != OP_READ && r_count != '1) begin
                n_count = r_count + 1'b1;
            end
            if (last_col) begin
                n_src_row  = src_next_row;
                n_src_ptr  = src_next_row;
                n_dst_row  = dst_next_row;
                n_dst_ptr  = dst_next_row;
                n_col_left = r_ncols;
                n_row_left = r_row_left - 1'b1;
            end else begin
                n_src_ptr  = r_src_ptr + 1'b1;
                n_dst_ptr  = r_dst_ptr + 1'b1;
                n_col_left = r_col_left - 1'b1;
            end
        end

        if (tail) begin
            n_result.read_data      = (r_op == OP_READ) ? rdata_m : 32'd0;
            n_result.pixels_written = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_IDLE;
            r_cp_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cp_valid <= n_cp_valid;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_deep       <= n_deep;
        r_value      <= n_value;
        r_src_stride <= n_src_stride;
        r_dst_stride <= n_dst_stride;
        r_ncols      <= n_ncols;
        r_col_left   <= n_col_left;
        r_row_left   <= n_row_left;
        r_src_row    <= n_src_row;
        r_src_ptr    <= n_src_ptr;
        r_dst_row    <= n_dst_row;
        r_dst_ptr    <= n_dst_ptr;
        r_count      <= n_count;
        r_cp_addr    <= n_cp_addr;
        r_result     <= n_result;
    end

    // pixel memory, read data registered
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[r_src_ptr];
    end

    // write-to-read bypass for the same address in the same cycle
    always_ff @(posedge i_clk) begin
        r_byp     <= we && (waddr == r_src_ptr);
        r_bypdata <= wdata;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: rtl/core/rect_fill_and_blit_engine.sv
// ----------------------------------------------------------------------------
// rect_fill_and_blit_engine: 2D fill and copy engine over a pixel memory
// Writes or reads single pixels, fills rectangles and copies rectangles
// within a local pixel memory, 8-bit or 32-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low. busy rises while the two-entry command queue is full.
//   Result channel: o_done pulses for one cycle with o_result; it cannot be
//   held off. Exactly one result per command, in command order.
//   Config channel: i_cfg_valid/o_cfg_ready with register index and data;
//   o_cfg_ready is always high. Write only while no command is in flight.
// Flow:
//   An accepted command waits in the queue until the back end is idle, which
//   pops it, walks its R rows by C columns (write and read count as 1 by 1)
//   and then raises o_done with o_result; an empty rectangle skips the walk.
//   The walker stores one pixel per cycle through the single write port of
//   the pixel memory; the queue takes new commands while a walk runs.
// Reset:
//   i_rst_n (synchronous, active low) clears the queue, walker and config
//   (pixel depth comes up as 32-bit). Pixel memory is not cleared: an entry
//   holds garbage until written.
// ----------------------------------------------------------------------------
module rect_fill_and_blit_engine #(
    parameter int PIXEL_WORDS = rfb_pkg::PIXEL_WORDS_DEF,
    parameter int MAX_SIDE    = rfb_pkg::MAX_SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // command channel
    input  logic                           start,
    output logic                           busy,
    input  rfb_pkg::t_cmd                  i_cmd,
    // result channel
    output logic                           o_done,
    output rfb_pkg::t_result               o_result
);
    import rfb_pkg::*;

    // front -> queue
    logic  q_push, q_full;
    t_desc q_in_desc;
    // queue -> back
    logic  q_valid, q_pop;
    t_desc q_out_desc;

    // front end: config registers, clipping, start address math
    rfb_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_desc      (q_in_desc)
    );

    // decouples command acceptance from the pixel walk
    rfb_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_out_desc)
    );

    // back end: pixel walker and memory, one pixel per cycle
    rfb_back #(
        .PIXEL_WORDS (PIXEL_WORDS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_desc   (q_out_desc),
        .o_pop    (q_pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// File: tb/rfb_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfb_checker: result checker for the rectangle fill and blit engine
// Snoops config writes and accepted commands, keeps a shadow pixel memory,
// works out each command's result and compares it with what the engine returns.
// ----------------------------------------------------------------------------
module rfb_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [rfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  rfb_pkg::t_cmd                  i_cmd,
    input  logic                           i_done,
    input  rfb_pkg::t_result               i_result,
    output int                             o_pending,
    output int                             o_fail_count
);
    import rfb_pkg::*;

    localparam int SIDE_CAP   = MAX_SIDE_DEF;
    localparam int COUNT_CAP  = (1 << COUNT_W) - 1;
    localparam int PRINT_CAP  = 200;

    logic [31:0] shadow_pixels [0:PIXEL_WORDS_DEF-1];
    logic [15:0] dst_base, src_base;
    logic [10:0] dst_width, dst_height, src_width, src_height;
    logic        deep;

    t_result due_results [$];
    int      pending    = 0;
    int      mismatches = 0;

    assign o_pending    = pending;
    assign o_fail_count = mismatches;

    function automatic int clip_side(int v);
        return (v > SIDE_CAP) ? SIDE_CAP : v;
    endfunction

    function automatic int min_of(int a, int b);
        return (a < b) ? a : b;
    endfunction

    // surface index, wraps with the memory size
    function automatic logic [15:0] cell_at(int base, int stride, int row, int col);
        int a;
        a = base + row * stride + col;
        return a[15:0];
    endfunction

    // applies one command to the shadow memory and returns the result it is due
    task automatic paint_and_count(input t_cmd c, output t_result r);
        logic [31:0] mask;
        logic [31:0] px;
        int dw, dh, sw, sh, x0, y0, x1, y1, dx0, dy0, count;
        mask  = deep ? 32'hFFFF_FFFF : 32'h0000_00FF;
        dw    = clip_side(dst_width);
        dh    = clip_side(dst_height);
        sw    = clip_side(src_width);
        sh    = clip_side(src_height);
        count = 0;
        r     = '0;
        case (c.mode)
            MODE_WRITE: begin
                shadow_pixels[c.address] = c.value & mask;
                count = 1;
            end
            MODE_READ: begin
                r.read_data = shadow_pixels[c.address] & mask;
            end
            MODE_FILL: begin
                x0 = c.has_rect ? int'(c.rect_x) : 0;
                y0 = c.has_rect ? int'(c.rect_y) : 0;
                x1 = c.has_rect ? min_of(int'(c.rect_x) + int'(c.rect_w), dw) : dw;
                y1 = c.has_rect ? min_of(int'(c.rect_y) + int'(c.rect_h), dh) : dh;
                for (int row = y0; row < y1; row++) begin
                    for (int col = x0; col < x1; col++) begin
                        shadow_pixels[cell_at(dst_base, dw, row, col)] = c.value & mask;
                        count++;
                    end
                end
            end
            MODE_COPY: begin
                x0  = c.has_rect ? int'(c.rect_x) : 0;
                y0  = c.has_rect ? int'(c.rect_y) : 0;
                x1  = c.has_rect ? min_of(int'(c.rect_x) + int'(c.rect_w), sw) : sw;
                y1  = c.has_rect ? min_of(int'(c.rect_y) + int'(c.rect_h), sh) : sh;
                dx0 = c.has_dest ? int'(c.dest_x) : 0;
                dy0 = c.has_dest ? int'(c.dest_y) : 0;
                // row-major, each read sees earlier stores (overlap)
                for (int k = 0; dy0 + k < dh && y0 + k < y1; k++) begin
                    for (int j = 0; dx0 + j < dw && x0 + j < x1; j++) begin
                        px = shadow_pixels[cell_at(src_base, sw, y0 + k, x0 + j)];
                        shadow_pixels[cell_at(dst_base, dw, dy0 + k, dx0 + j)] = px & mask;
                        count++;
                    end
                end
            end
            default: ;
        endcase
        r.pixels_written = COUNT_W'((count > COUNT_CAP) ? COUNT_CAP : count);
    endtask

    task automatic flag(string what, logic [31:0] want, logic [31:0] got);
        if (mismatches < PRINT_CAP) begin
            $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
        end
        mismatches++;
    endtask

    task automatic compare_result(t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            flag("unexpected result, read_data", 'x, got.read_data);
            return;
        end
        want = due_results.pop_front();
        if (got.read_data !== want.read_data) begin
            flag("read_data", want.read_data, got.read_data);
        end
        if (got.pixels_written !== want.pixels_written) begin
            flag("pixels_written", 32'(want.pixels_written), 32'(got.pixels_written));
        end
    endtask

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            dst_base   = '0;
            dst_width  = '0;
            dst_height = '0;
            src_base   = '0;
            src_width  = '0;
            src_height = '0;
            deep       = 1'b1;
            due_results.delete();
            pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DST_BASE:   dst_base   = i_cfg_data;
                    CFG_DST_WIDTH:  dst_width  = i_cfg_data[10:0];
                    CFG_DST_HEIGHT: dst_height = i_cfg_data[10:0];
                    CFG_SRC_BASE:   src_base   = i_cfg_data;
                    CFG_SRC_WIDTH:  src_width  = i_cfg_data[10:0];
                    CFG_SRC_HEIGHT: src_height = i_cfg_data[10:0];
                    CFG_DEEP:       deep       = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_done) begin
                compare_result(i_result);
            end
            if (i_start && !i_busy) begin
                paint_and_count(i_cmd, due);
                due_results.push_back(due);
            end
            pending <= due_results.size();
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the rectangle fill and blit engine
// Drives config writes and commands with random idle gaps; a side checker
// predicts every result from a shadow pixel memory and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import rfb_pkg::*;

    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 50;
    localparam int TAIL_CYCLES   = 20;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd       = '0;
    logic                  o_done;
    t_result               o_result;
    int                    pending;
    int                    mismatches;

    rect_fill_and_blit_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    // checker sits beside the block and only watches its ports
    rfb_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_pending    (pending),
        .o_fail_count (mismatches)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: the slowest legal run is well under 20 ms
    initial begin
        #(100_000_000);
        $display("Mismatches found");
        $finish;
    end

    // register value as the block sees it: 11 bits, clipped to the max side
    function automatic int clip_side(int v);
        int m;
        m = v & 2047;
        return (m > MAX_SIDE_DEF) ? MAX_SIDE_DEF : m;
    endfunction

    // keeps the low bits meaningful, sometimes sets the unused upper ones
    function automatic logic [15:0] with_junk_bits(int v, int keep);
        logic [15:0] d;
        d = 16'(v) & ((16'd1 << keep) - 16'd1);
        if ($urandom_range(0, 3) == 0) begin
            d = d | (16'($urandom) << keep);
        end
        return d;
    endfunction

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    // every field random within its legal range; modes ignore what they do not use
    function automatic t_cmd scrambled_cmd();
        t_cmd c;
        c.mode     = t_mode'($urandom_range(0, 3));
        c.address  = 16'($urandom);
        c.value    = $urandom;
        c.has_rect = 1'($urandom);
        c.rect_x   = 10'($urandom);
        c.rect_y   = 10'($urandom);
        c.rect_w   = 11'($urandom_range(0, 1024));
        c.rect_h   = 11'($urandom_range(0, 1024));
        c.has_dest = 1'($urandom);
        c.dest_x   = 10'($urandom);
        c.dest_y   = 10'($urandom);
        return c;
    endfunction

    function automatic t_cmd pixel_op(t_mode m, logic [15:0] addr, logic [31:0] val);
        t_cmd c;
        c         = scrambled_cmd();
        c.mode    = m;
        c.address = addr;
        c.value   = val;
        return c;
    endfunction

    function automatic t_cmd area_op(t_mode m, logic [31:0] val, logic has_r,
                                     int rx, int ry, int rw, int rh,
                                     logic has_d, int dx, int dy);
        t_cmd c;
        c          = scrambled_cmd();
        c.mode     = m;
        c.value    = val;
        c.has_rect = has_r;
        c.rect_x   = 10'(rx);
        c.rect_y   = 10'(ry);
        c.rect_w   = 11'(rw);
        c.rect_h   = 11'(rh);
        c.has_dest = has_d;
        c.dest_x   = 10'(dx);
        c.dest_y   = 10'(dy);
        return c;
    endfunction

    // rectangles mostly aimed at the surfaces so walks do real work;
    // the rest keeps the full-range values (mostly clipped to nothing)
    function automatic t_cmd random_command(int dw, int dh, int sw, int sh);
        t_cmd c;
        int   tw, th;
        c = scrambled_cmd();
        case ($urandom_range(0, 9))
            0, 1:    c.mode = MODE_WRITE;
            2, 3:    c.mode = MODE_READ;
            4, 5, 6: c.mode = MODE_FILL;
            default: c.mode = MODE_COPY;
        endcase
        tw = (c.mode == MODE_COPY) ? sw : dw;
        th = (c.mode == MODE_COPY) ? sh : dh;
        c.has_rect = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 4) != 0) begin
            c.rect_x = 10'($urandom_range(0, (tw > 0) ? tw - 1 : 0));
            c.rect_y = 10'($urandom_range(0, (th > 0) ? th - 1 : 0));
            c.rect_w = 11'(clip_side($urandom_range(0, tw - int'(c.rect_x) + 2)));
            c.rect_h = 11'(clip_side($urandom_range(0, th - int'(c.rect_y) + 2)));
            if ($urandom_range(0, 9) == 0) begin
                c.rect_w = 11'(MAX_SIDE_DEF);
                c.rect_h = 11'(MAX_SIDE_DEF);
            end
        end
        c.has_dest = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 4) != 0) begin
            c.dest_x = 10'($urandom_range(0, (dw > 0) ? dw - 1 : 0));
            c.dest_y = 10'($urandom_range(0, (dh > 0) ? dh - 1 : 0));
        end
        return c;
    endfunction

    // surface shape: mostly small, sometimes empty or one side oversized
    task automatic pick_surface(output int w, output int h);
        case ($urandom_range(0, 9))
            0: begin
                w = 0;
                h = $urandom_range(0, 40);
            end
            1: begin
                w = $urandom_range(0, 40);
                h = 0;
            end
            2: begin
                w = $urandom_range(1000, 2047);
                h = $urandom_range(1, 2);
            end
            3: begin
                w = $urandom_range(1, 2);
                h = $urandom_range(1000, 2047);
            end
            default: begin
                w = $urandom_range(1, 32);
                h = $urandom_range(1, 32);
            end
        endcase
    endtask

    // command transaction: start stays high until the block takes it.
    // busy is sampled right at the edge, before the block updates it.
    task automatic send_command(t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_start_low(int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every due result has come back.
    // The first edge lets the checker count the last accepted command.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // config transaction; valid is left high for back-to-back writes
    task automatic write_reg(t_cfg_index idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // registers only change with nothing in flight
    task automatic program_surfaces(int dbase, int dw, int dh,
                                    int sbase, int sw, int sh, int deep);
        drain_results();
        write_reg(CFG_DST_BASE,   16'(dbase));
        write_reg(CFG_DST_WIDTH,  with_junk_bits(dw, 11));
        write_reg(CFG_DST_HEIGHT, with_junk_bits(dh, 11));
        write_reg(CFG_SRC_BASE,   16'(sbase));
        write_reg(CFG_SRC_WIDTH,  with_junk_bits(sw, 11));
        write_reg(CFG_SRC_HEIGHT, with_junk_bits(sh, 11));
        write_reg(CFG_DEEP,       with_junk_bits(deep, 1));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int dw_reg, dh_reg, sw_reg, sh_reg;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // -- directed: one 1024 x 64 surface spanning the whole memory, 32-bit
        program_surfaces(0, 1024, 64, 0, 1024, 64, 1);
        // whole-surface fill writes every memory entry, so no later read
        // or copy can touch an entry that was never written
        send_command(area_op(MODE_FILL, 32'hA5A5_5A5A, 1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_command(pixel_op(MODE_WRITE, 16'h0000, 32'hFFFF_FFFF));
        hold_start_low(idle_gap());
        send_command(pixel_op(MODE_WRITE, 16'hFFFF, 32'h0000_0000));
        send_command(pixel_op(MODE_READ, 16'h0000, 32'h0));
        send_command(pixel_op(MODE_READ, 16'hFFFF, 32'h0));
        send_command(pixel_op(MODE_READ, 16'h04D2, 32'h0));
        // overrun clipped down to the bottom-right pixel
        send_command(area_op(MODE_FILL, 32'h1234_5678, 1'b1, 1023, 63, 1024, 1024,
                             1'b0, 0, 0));
        send_command(pixel_op(MODE_READ, 16'hFFFF, 32'h0));
        // empty rectangles: zero width, and rows past the surface
        send_command(area_op(MODE_FILL, 32'hDEAD_0001, 1'b1, 5, 5, 0, 7, 1'b0, 0, 0));
        send_command(area_op(MODE_FILL, 32'hDEAD_0002, 1'b1, 1023, 1023, 1, 1,
                             1'b0, 0, 0));
        // overlapping copy inside one surface
        send_command(area_op(MODE_COPY, 32'h0, 1'b1, 0, 0, 8, 4, 1'b1, 3, 2));
        hold_start_low(idle_gap());
        // no destination origin: lands at 0,0
        send_command(area_op(MODE_COPY, 32'h0, 1'b1, 10, 10, 5, 5, 1'b0, 700, 9));
        // destination runs off the right and bottom edges
        send_command(area_op(MODE_COPY, 32'h0, 1'b1, 0, 0, 16, 8, 1'b1, 1020, 60));
        // source clipped to its right and bottom edges
        send_command(area_op(MODE_COPY, 32'h0, 1'b1, 1020, 60, 1024, 1024, 1'b1, 100, 0));
        // whole source into a corner of the destination
        send_command(area_op(MODE_COPY, 32'h0, 1'b0, 0, 0, 0, 0, 1'b1, 1000, 40));

        // -- directed: 8-bit pixels, bases near the top so indexes wrap,
        // width registers oversized (2047 and 1500 act as 1024)
        program_surfaces(16'hFFFA, 16'hFFFF, 3, 16'hFFF0, 1500, 2, 0);
        send_command(pixel_op(MODE_WRITE, 16'd77, 32'hDEAD_BEEF));
        send_command(pixel_op(MODE_READ, 16'd77, 32'h0));
        send_command(area_op(MODE_FILL, 32'h1122_3344, 1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_command(area_op(MODE_COPY, 32'h0, 1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_command(pixel_op(MODE_READ, 16'hFFFF, 32'h0));

        // -- directed: zero-sized surfaces, nothing is stored
        program_surfaces(0, 0, 0, 0, 0, 0, 1);
        send_command(area_op(MODE_FILL, 32'h5555_AAAA, 1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_command(area_op(MODE_COPY, 32'h0, 1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_command(area_op(MODE_FILL, 32'h5555_AAAA, 1'b1, 0, 0, 1024, 1024,
                             1'b0, 0, 0));

        // -- directed: 1024 x 129 fill overflows the pixel counter
        program_surfaces(0, 1024, 129, 0, 1024, 129, 1);
        send_command(area_op(MODE_FILL, 32'h0F0F_F0F0, 1'b0, 0, 0, 0, 0, 1'b0, 0, 0));
        send_command(pixel_op(MODE_READ, 16'h8001, 32'h0));

        // -- random: new surfaces and depth per phase; every third phase runs
        // back to back, the others with random gaps
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick_surface(dw_reg, dh_reg);
            pick_surface(sw_reg, sh_reg);
            program_surfaces($urandom_range(0, 65535), dw_reg, dh_reg,
                             $urandom_range(0, 65535), sw_reg, sh_reg,
                             $urandom_range(0, 1));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_command(random_command(clip_side(dw_reg), clip_side(dh_reg),
                                            clip_side(sw_reg), clip_side(sh_reg)));
                if (ph % 3 != 0) begin
                    hold_start_low(idle_gap());
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/rfb_pkg.sv
rtl/core/rfb_front.sv
rtl/core/rfb_fifo.sv
rtl/core/rfb_back.sv
rtl/core/rect_fill_and_blit_engine.sv
tb/rfb_checker.sv
tb/testbench.sv
